[rtl/core/neuron_dot_product_activation_core_defines.svh]
// Assertion helpers shared by the neuron core.
`ifndef NEURON_DOT_PRODUCT_ACTIVATION_CORE_DEFINES_SVH
`define NEURON_DOT_PRODUCT_ACTIVATION_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NDPA_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("neuron core check failed");

// Next-cycle implication, checked outside reset.
`define NDPA_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("neuron core check failed");

`endif

[rtl/core/ndpa_pkg.sv]
package ndpa_pkg;

	localparam int IDX_W     = 4;
	localparam int VALUE_W   = 16;
	localparam int ACC_W     = 32;
	localparam int GAIN_W    = 8;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;
	localparam int STORE_DEPTH = 16;
	localparam int Y_W       = 15;

	localparam logic FUNC_WEIGHT = 1'b0;
	localparam logic FUNC_FEED   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b1;

	localparam logic [MODE_W-1:0] MODE_STEP    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SIGN    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SIGMOID = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TANH    = 2'd3;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd16;
	localparam logic [Y_W-1:0]    Y_MAX      = 15'd32767;
	// First saturated table segment; from it on the output is saturated.
	localparam logic [3:0]        TANH_LAST  = 4'd12;

	// tanh(k/2) in unsigned Q0.15 for k = 0..12.
	function automatic logic [Y_W-1:0] tanh_point(input logic [3:0] k);
		logic [Y_W-1:0] r;
		unique case (k)
			4'd0:    r = 15'd0;
			4'd1:    r = 15'd15143;
			4'd2:    r = 15'd24956;
			4'd3:    r = 15'd29660;
			4'd4:    r = 15'd31589;
			4'd5:    r = 15'd32329;
			4'd6:    r = 15'd32606;
			4'd7:    r = 15'd32708;
			4'd8:    r = 15'd32746;
			4'd9:    r = 15'd32760;
			4'd10:   r = 15'd32765;
			default: r = 15'd32767;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/ndpa_if.sv]
interface ndpa_item_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  func;
	logic [ndpa_pkg::IDX_W-1:0]            element_index;
	logic signed [ndpa_pkg::VALUE_W-1:0]   element_value;
	logic                                  last_element;

	modport source (output valid, func, element_index, element_value, last_element,
		input ready);
	modport sink (input valid, func, element_index, element_value, last_element,
		output ready);
endinterface

interface ndpa_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ndpa_pkg::VALUE_W-1:0]   activation;
	logic                                  fired;

	modport source (output valid, activation, fired, input ready);
	modport sink (input valid, activation, fired, output ready);
endinterface

[rtl/core/ndpa_ram.sv]
module ndpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/neuron_dot_product_activation_core.sv]
// The result of the last fed word passes stages 1 to 5, then the output register.
// Throughput: one input word per cycle; weight-store read, multiply, accumulate,
// gain multiply, table lookup and interpolation each take one pipeline stage.
// Input stalls only while a result in the last stage waits on a full output register.
// Reset clears the accumulator, valids and config (step mode, gain 1.0);
// the weight store is not cleared and must be written before use.
`include "neuron_dot_product_activation_core_defines.svh"

module neuron_dot_product_activation_core #(
	parameter int VECTOR_LENGTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ndpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ndpa_pkg::CFG_W-1:0]         cfg_wdata,
	ndpa_item_if.sink                          item,
	ndpa_result_if.source                      result
);

	localparam int IDX_W = ndpa_pkg::IDX_W;
	localparam int CMP_W = ($clog2(VECTOR_LENGTH + 1) > IDX_W) ?
		$clog2(VECTOR_LENGTH + 1) : IDX_W + 1;

	// Configuration registers.
	logic [ndpa_pkg::MODE_W-1:0] mode_q;
	logic [ndpa_pkg::GAIN_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ndpa_pkg::MODE_STEP;
			gain_q <= ndpa_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ndpa_pkg::CFG_MODE: mode_q <= cfg_wdata[ndpa_pkg::MODE_W-1:0];
				ndpa_pkg::CFG_GAIN: gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic stall;
	logic accept;
	logic in_range;
	logic [ndpa_pkg::VALUE_W-1:0] weight_rd;

	assign item.ready = !stall;
	assign accept = item.valid && item.ready;
	assign in_range = CMP_W'(item.element_index) < CMP_W'(VECTOR_LENGTH);

	ndpa_ram #(
		.WIDTH(ndpa_pkg::VALUE_W),
		.DEPTH(ndpa_pkg::STORE_DEPTH)
	) u_weights (
		.clk   (clk),
		.we    (accept && item.func == ndpa_pkg::FUNC_WEIGHT && in_range),
		.waddr (item.element_index),
		.wdata (item.element_value),
		.re    (accept && item.func == ndpa_pkg::FUNC_FEED),
		.raddr (item.element_index),
		.rdata (weight_rd)
	);

	// Stage 1: weight word arrives from the store.
	logic                                feed_s1, last_s1, range_s1;
	logic signed [ndpa_pkg::VALUE_W-1:0] value_s1;
	// Stage 2: product ready for accumulation.
	logic                                feed_s2, last_s2;
	logic signed [ndpa_pkg::ACC_W-1:0]   prod_s2;
	logic signed [ndpa_pkg::ACC_W-1:0]   acc_q;
	// Stage 3: final sum; stage 4: scaled sum.
	logic                                res_s3, res_s4;
	logic signed [ndpa_pkg::ACC_W-1:0]   sum_s3;
	logic signed [40:0]                  z_s4;
	// Stage 5: interpolation operands.
	logic                                res_s5, neg_s5, pos_s5, sat_s5;
	logic [ndpa_pkg::Y_W-1:0]            lo_s5, diff_s5, frac_s5;
	// Output register.
	logic                                out_valid_q, fired_q;
	logic signed [ndpa_pkg::VALUE_W-1:0] act_q;

	// Saturating accumulate.
	logic signed [ndpa_pkg::ACC_W:0]     sum_wide;
	logic signed [ndpa_pkg::ACC_W-1:0]   sum_sat;

	always_comb begin
		sum_wide = {acc_q[ndpa_pkg::ACC_W-1], acc_q} + {prod_s2[ndpa_pkg::ACC_W-1], prod_s2};
		if (sum_wide[ndpa_pkg::ACC_W] != sum_wide[ndpa_pkg::ACC_W-1]) begin
			sum_sat = sum_wide[ndpa_pkg::ACC_W] ? {1'b1, {(ndpa_pkg::ACC_W-1){1'b0}}} :
				{1'b0, {(ndpa_pkg::ACC_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[ndpa_pkg::ACC_W-1:0];
		end
	end

	// Magnitude of z in Q20.16, halved for the sigmoid, then split into
	// table segment and fraction.
	logic        neg_z, pos_z, sat_z;
	logic [40:0] abs_z;
	logic [35:0] mag, tab_in;
	logic [3:0]  seg;
	logic [ndpa_pkg::Y_W-1:0] lo_pt, hi_pt;

	always_comb begin
		neg_z  = z_s4[40];
		pos_z  = !neg_z && (|z_s4);
		abs_z  = neg_z ? 41'(-z_s4) : 41'(z_s4);
		mag    = abs_z[39:4];
		tab_in = (mode_q == ndpa_pkg::MODE_SIGMOID) ? {1'b0, mag[35:1]} : mag;
		seg    = tab_in[18:15];
		sat_z  = (|tab_in[35:19]) || (seg >= ndpa_pkg::TANH_LAST);
		lo_pt  = ndpa_pkg::tanh_point(seg);
		hi_pt  = ndpa_pkg::tanh_point(4'(seg + 4'd1));
	end

	// Interpolation and the activation modes.
	logic [29:0]                         interp;
	logic [ndpa_pkg::Y_W-1:0]            y;
	logic [16:0]                         sig_t;
	logic signed [ndpa_pkg::VALUE_W-1:0] act_d;
	logic                                fired_d;

	always_comb begin
		interp = diff_s5 * frac_s5;
		y      = sat_s5 ? ndpa_pkg::Y_MAX : ndpa_pkg::Y_W'(lo_s5 + interp[29:15]);
		sig_t  = pos_s5 ? 17'd32768 + 17'(y) : 17'd32768 - 17'(y);
		unique case (mode_q)
			ndpa_pkg::MODE_STEP: begin
				fired_d = !neg_s5;
				act_d   = fired_d ? 16'sh7fff : 16'sh0000;
			end
			ndpa_pkg::MODE_SIGN: begin
				fired_d = pos_s5;
				act_d   = fired_d ? 16'sh7fff : 16'sh0000;
			end
			ndpa_pkg::MODE_SIGMOID: begin
				fired_d = pos_s5;
				act_d   = $signed(sig_t[16:1]);
			end
			default: begin
				fired_d = pos_s5;
				act_d   = neg_s5 ? -$signed({1'b0, y}) : $signed({1'b0, y});
			end
		endcase
	end

	// The whole pipeline holds only when a finished word cannot move on.
	assign stall = res_s5 && out_valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1 <= 1'b0;
			feed_s2 <= 1'b0;
			res_s3  <= 1'b0;
			res_s4  <= 1'b0;
			res_s5  <= 1'b0;
			acc_q   <= '0;
		end else if (!stall) begin
			feed_s1 <= accept && item.func == ndpa_pkg::FUNC_FEED;
			feed_s2 <= feed_s1;
			res_s3  <= feed_s2 && last_s2;
			res_s4  <= res_s3;
			res_s5  <= res_s4;
			if (feed_s2) begin
				acc_q <= last_s2 ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			last_s1  <= item.last_element;
			range_s1 <= in_range;
			value_s1 <= item.element_value;
			last_s2  <= last_s1;
			// Kept apart from the zero case so the product stays a signed multiply.
			if (range_s1) begin
				prod_s2 <= $signed(weight_rd) * value_s1;
			end else begin
				prod_s2 <= '0;
			end
			sum_s3   <= sum_sat;
			z_s4     <= sum_s3 * $signed({1'b0, gain_q});
			neg_s5   <= neg_z;
			pos_s5   <= pos_z;
			sat_s5   <= sat_z;
			lo_s5    <= lo_pt;
			diff_s5  <= ndpa_pkg::Y_W'(hi_pt - lo_pt);
			frac_s5  <= tab_in[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_s5 && !stall) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s5 && !stall) begin
			act_q   <= act_d;
			fired_q <= fired_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.activation = act_q;
	assign result.fired      = fired_q;

	`NDPA_ASSERT_NXT(a_weight_skips_mac, clk, arst_n, accept && item.func == ndpa_pkg::FUNC_WEIGHT, !feed_s1)
	`NDPA_ASSERT_NXT(a_last_clears_acc, clk, arst_n, feed_s2 && last_s2 && !stall, acc_q == '0)
	`NDPA_ASSERT_IMP(a_act_not_min, clk, arst_n, out_valid_q, act_q != 16'sh8000)

endmodule
